@@ design/ipv6_route_table_lpm_top_assert.svh @@
// ----------------------------------------------------------------------------
// ipv6_route_table_lpm_top_assert.svh
// Assertion macros for the route table; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IPV6_ROUTE_TABLE_LPM_TOP_ASSERT_SVH
`define IPV6_ROUTE_TABLE_LPM_TOP_ASSERT_SVH
`ifndef SYNTH
`define RTLPM_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("route table assertion failed");
`define RTLPM_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("route table assertion failed");
`else
`define RTLPM_AST_NEXT(lbl, ante, cons)
`define RTLPM_AST_SAME(lbl, ante, cons)
`endif
`endif

@@ design/rtlpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtlpm_pkg
// Shared constants and types of the IPv6 route table.
// ----------------------------------------------------------------------------
`default_nettype none
package rtlpm_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [3:0] RS_ADDED     = 4'd0;
    localparam logic [3:0] RS_REFRESHED = 4'd1;
    localparam logic [3:0] RS_REPLACED  = 4'd2;
    localparam logic [3:0] RS_IGNORED   = 4'd3;
    localparam logic [3:0] RS_DELETED   = 4'd4;
    localparam logic [3:0] RS_DEL_MISS  = 4'd5;
    localparam logic [3:0] RS_FULL      = 4'd6;
    localparam logic [3:0] RS_HIT       = 4'd7;
    localparam logic [3:0] RS_MISS      = 4'd8;

    localparam logic [7:0] COST_INFINITY = 8'd16;
    localparam logic [7:0] ADDR_BITS     = 8'd128;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} t_state;

    // token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic             valid;
        logic [1:0]       opcode;
        logic [127:0]     addr;
        logic [7:0]       len;
        logic [127:0]     source;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             found_src_eq;
        logic [7:0]       found_cost;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
        logic             best_hit;
        logic [7:0]       best_len;
        logic [127:0]     best_hop;
        logic [7:0]       best_port;
    } t_tok;

    // write-back broadcast to the row
    typedef struct packed {
        logic             en;
        logic             clr;
        logic             cost_only;
        logic [IDX_W-1:0] idx;
        logic [127:0]     prefix;
        logic [7:0]       len;
        logic [127:0]     hop;
        logic [7:0]       port;
        logic [7:0]       cost;
        logic [127:0]     source;
    } t_wr;
endpackage
`default_nettype wire

@@ design/rtlpm_if.sv @@
// ----------------------------------------------------------------------------
// rtlpm_in_if / rtlpm_out_if
// Request and response channels of the route table.
// ----------------------------------------------------------------------------
`default_nettype none
interface rtlpm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [63:0] hop_hi;
    logic [63:0] hop_lo;
    logic [7:0]  port_in;
    logic [7:0]  cost_in;
    logic [63:0] source_hi;
    logic [63:0] source_lo;
    modport source (output valid, opcode, addr_hi, addr_lo, prefix_len, hop_hi, hop_lo,
                    port_in, cost_in, source_hi, source_lo, input ready);
    modport sink (input valid, opcode, addr_hi, addr_lo, prefix_len, hop_hi, hop_lo,
                  port_in, cost_in, source_hi, source_lo, output ready);
endinterface

interface rtlpm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [63:0] hop_out_hi;
    logic [63:0] hop_out_lo;
    logic [7:0]  port_out;
    modport source (output valid, status, hop_out_hi, hop_out_lo, port_out, input ready);
    modport sink (input valid, status, hop_out_hi, hop_out_lo, port_out, output ready);
endinterface
`default_nettype wire

@@ design/rtlpm_cell.sv @@
// ----------------------------------------------------------------------------
// rtlpm_cell
// One table slot: holds the route and updates the passing token.
// ----------------------------------------------------------------------------
`default_nettype none
module rtlpm_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [rtlpm_pkg::IDX_W-1:0] i_idx,
    input  wire rtlpm_pkg::t_tok         i_tok,
    input  wire rtlpm_pkg::t_wr          i_wr,
    output rtlpm_pkg::t_tok              o_tok
);
    logic            r_valid;
    logic [127:0]    r_prefix;
    logic [7:0]      r_len;
    logic [127:0]    r_hop;
    logic [7:0]      r_port;
    logic [7:0]      r_cost;
    logic [127:0]    r_source;
    logic            r_tok_vld;
    rtlpm_pkg::t_tok r_tok;
    rtlpm_pkg::t_tok n_tok;
    logic [127:0]    w_mask;
    logic            w_covers;
    logic            w_exact;
    logic            w_sel;

    // top len bits set; zero for len 0, all ones from 128
    assign w_mask   = ~({128{1'b1}} >> r_len);
    assign w_covers = (r_len <= rtlpm_pkg::ADDR_BITS) &&
                      (((r_prefix ^ i_tok.addr) & w_mask) == '0);
    assign w_exact  = (r_len == i_tok.len) && (r_prefix == i_tok.addr);
    assign w_sel    = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.opcode == rtlpm_pkg::OP_QUERY) begin
            if (r_valid && w_covers && (!i_tok.best_hit || r_len > i_tok.best_len)) begin
                n_tok.best_hit  = 1'b1;
                n_tok.best_len  = r_len;
                n_tok.best_hop  = r_hop;
                n_tok.best_port = r_port;
            end
        end else if (r_valid) begin
            if (!i_tok.found && w_exact) begin
                n_tok.found        = 1'b1;
                n_tok.found_idx    = i_idx;
                n_tok.found_src_eq = (r_source == i_tok.source);
                n_tok.found_cost   = r_cost;
            end
        end else if (!i_tok.free_hit) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.valid;
            if (w_sel) begin
                r_valid <= !i_wr.clr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (w_sel && !i_wr.clr) begin
            r_cost <= i_wr.cost;
            if (!i_wr.cost_only) begin
                r_prefix <= i_wr.prefix;
                r_len    <= i_wr.len;
                r_hop    <= i_wr.hop;
                r_port   <= i_wr.port;
                r_source <= i_wr.source;
            end
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_vld;
    end
endmodule
`default_nettype wire

@@ design/ipv6_route_table_lpm_top.sv @@
// ----------------------------------------------------------------------------
// ipv6_route_table_lpm_top
// IPv6 route table with longest prefix match over a row of slot cells.
// ----------------------------------------------------------------------------
// One word at a time: an accepted request walks the row of TABLE_DEPTH slot
// cells, one cell per cycle, collecting the exact match, the first free slot
// or the longest covering prefix. When it leaves the last cell any table
// write is made and the response is registered, and the next request is
// taken in the cycle after the response is accepted.
// Slot valid bits clear at reset; no clearing pass is needed.
`default_nettype none
`include "ipv6_route_table_lpm_top_assert.svh"
module ipv6_route_table_lpm_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rtlpm_in_if.sink    i_req,
    rtlpm_out_if.source o_rsp
);
    localparam int D = rtlpm_pkg::TABLE_DEPTH;

    rtlpm_pkg::t_state r_state, n_state;
    rtlpm_pkg::t_tok   w_chain [D+1];
    rtlpm_pkg::t_tok   w_tail;
    rtlpm_pkg::t_wr    w_wr;
    logic              w_in_ready;
    logic              w_out_valid;
    logic              w_acc;
    logic [127:0]      r_hop;
    logic [7:0]        r_port;
    logic [7:0]        r_cost;
    logic [3:0]        r_status, n_status;
    logic [127:0]      r_hop_out, n_hop_out;
    logic [7:0]        r_port_out, n_port_out;

    assign w_acc = i_req.valid && w_in_ready;

    always_comb begin
        w_chain[0]              = '0;
        w_chain[0].valid        = w_acc;
        w_chain[0].opcode       = i_req.opcode;
        w_chain[0].addr         = {i_req.addr_hi, i_req.addr_lo};
        w_chain[0].len          = i_req.prefix_len;
        w_chain[0].source       = {i_req.source_hi, i_req.source_lo};
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        rtlpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (rtlpm_pkg::IDX_W'(g)),
            .i_tok   (w_chain[g]),
            .i_wr    (w_wr),
            .o_tok   (w_chain[g+1])
        );
    end
    assign w_tail = w_chain[D];

    // decision on the token leaving the row
    always_comb begin
        w_wr        = '0;
        w_wr.idx    = w_tail.found_idx;
        w_wr.prefix = w_tail.addr;
        w_wr.len    = w_tail.len;
        w_wr.hop    = r_hop;
        w_wr.port   = r_port;
        w_wr.cost   = r_cost;
        w_wr.source = w_tail.source;
        n_status    = rtlpm_pkg::RS_IGNORED;
        n_hop_out   = '0;
        n_port_out  = '0;
        case (w_tail.opcode)
            rtlpm_pkg::OP_QUERY: begin
                if (w_tail.best_hit) begin
                    n_status   = rtlpm_pkg::RS_HIT;
                    n_hop_out  = w_tail.best_hop;
                    n_port_out = w_tail.best_port;
                end else begin
                    n_status = rtlpm_pkg::RS_MISS;
                end
            end
            rtlpm_pkg::OP_DELETE: begin
                if (w_tail.found) begin
                    w_wr.en  = w_tail.valid;
                    w_wr.clr = 1'b1;
                    n_status = rtlpm_pkg::RS_DELETED;
                end else begin
                    n_status = rtlpm_pkg::RS_DEL_MISS;
                end
            end
            rtlpm_pkg::OP_INSERT: begin
                if (w_tail.found) begin
                    if (w_tail.found_src_eq) begin
                        w_wr.en        = w_tail.valid;
                        w_wr.cost_only = 1'b1;
                        n_status       = rtlpm_pkg::RS_REFRESHED;
                    end else if (w_tail.found_cost > r_cost) begin
                        w_wr.en  = w_tail.valid;
                        n_status = rtlpm_pkg::RS_REPLACED;
                    end
                end else if (r_cost == rtlpm_pkg::COST_INFINITY) begin
                    n_status = rtlpm_pkg::RS_IGNORED;
                end else if (!w_tail.free_hit) begin
                    n_status = rtlpm_pkg::RS_FULL;
                end else begin
                    w_wr.en  = w_tail.valid;
                    w_wr.idx = w_tail.free_idx;
                    n_status = rtlpm_pkg::RS_ADDED;
                end
            end
            default: begin
                n_status = rtlpm_pkg::RS_IGNORED;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rtlpm_pkg::S_IDLE: if (w_acc) n_state = rtlpm_pkg::S_SCAN;
            rtlpm_pkg::S_SCAN: if (w_tail.valid) n_state = rtlpm_pkg::S_RESP;
            rtlpm_pkg::S_RESP: if (o_rsp.ready) n_state = rtlpm_pkg::S_IDLE;
            default:           n_state = rtlpm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = (r_state == rtlpm_pkg::S_IDLE);
        w_out_valid = (r_state == rtlpm_pkg::S_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtlpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_hop  <= {i_req.hop_hi, i_req.hop_lo};
            r_port <= i_req.port_in;
            r_cost <= i_req.cost_in;
        end
        if (w_tail.valid) begin
            r_status   <= n_status;
            r_hop_out  <= n_hop_out;
            r_port_out <= n_port_out;
        end
    end

    assign i_req.ready      = w_in_ready;
    assign o_rsp.valid      = w_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.hop_out_hi = r_hop_out[127:64];
    assign o_rsp.hop_out_lo = r_hop_out[63:0];
    assign o_rsp.port_out   = r_port_out;

    `RTLPM_AST_NEXT(a_acc_scan, w_acc, r_state == rtlpm_pkg::S_SCAN)
    `RTLPM_AST_NEXT(a_tail_resp, w_tail.valid, w_out_valid)
    `RTLPM_AST_SAME(a_wr_tail, w_wr.en, w_tail.valid && r_state == rtlpm_pkg::S_SCAN)
    `RTLPM_AST_NEXT(a_resp_hold, w_out_valid && !o_rsp.ready, $stable(r_status))
endmodule
`default_nettype wire
